### rtl/swc_pkg.sv
package swc_pkg;

    // table geometry
    localparam int ROWS        = 64;
    localparam int LOG2_COLS   = 8;
    localparam int WEIGHT_BITS = 16;

    localparam int COLS      = 1 << LOG2_COLS;
    localparam int DEPTH     = ROWS * COLS;
    localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_BITS = $clog2(DEPTH);

    // running sum and the wider accumulator it saturates from
    localparam int SUM_BITS = 22;
    localparam int ACC_BITS = ((WEIGHT_BITS > SUM_BITS) ? WEIGHT_BITS : SUM_BITS) + 1;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    // stream widths
    localparam int S_DATA_BITS = 104;
    localparam int M_DATA_BITS = 24;

    // item kinds
    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic apply;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic last;
        logic clr_done;
        logic out_busy;
    } t_stat;

endpackage

### rtl/swc_ram.sv
module swc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/swc_ctrl.sv
module swc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  swc_pkg::t_stat i_stat,
    output swc_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_hold;

    // a predict item that closes a vector waits for room in the output register
    assign w_hold = (i_stat.func == swc_pkg::FUNC_PREDICT) && i_stat.last && i_stat.out_busy;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                if (!w_hold) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/swc_datapath.sv
module swc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swc_pkg::t_cmd                 i_cmd,
    output swc_pkg::t_stat                o_stat,
    input  logic                          i_func,
    input  logic [31:0]                   i_sketch_value,
    input  logic [31:0]                   i_hash_mult,
    input  logic [31:0]                   i_hash_offset,
    input  logic                          i_step_up,
    input  logic                          i_last,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic                          o_predicted_class,
    output logic [swc_pkg::SUM_BITS-1:0]  o_weight_total
);

    // item registers
    logic                            r_func;
    logic                            r_last;
    logic                            r_up;
    logic [swc_pkg::LOG2_COLS-1:0]   r_col;

    // vector state
    logic [swc_pkg::ROW_BITS-1:0]    r_row;
    logic signed [swc_pkg::SUM_BITS-1:0] r_sum;

    // clearing pass
    logic [swc_pkg::ADDR_BITS-1:0]   r_clr_addr;

    // output register
    logic                            r_out_valid;
    logic                            r_out_class;
    logic [swc_pkg::SUM_BITS-1:0]    r_out_total;

    logic [swc_pkg::LOG2_COLS-1:0]   w_prod;
    logic [swc_pkg::LOG2_COLS-1:0]   w_col;
    logic [swc_pkg::ADDR_BITS-1:0]   w_addr;
    logic [swc_pkg::WEIGHT_BITS-1:0] w_rdata;
    logic signed [swc_pkg::WEIGHT_BITS-1:0] w_weight;
    logic signed [swc_pkg::WEIGHT_BITS-1:0] w_weight_new;
    logic signed [swc_pkg::ACC_BITS-1:0]    w_acc;
    logic signed [swc_pkg::SUM_BITS-1:0]    w_sum_sat;
    logic                            w_we;
    logic [swc_pkg::ADDR_BITS-1:0]   w_waddr;
    logic [swc_pkg::WEIGHT_BITS-1:0] w_wdata;
    logic                            w_emit;

    // only the low column bits of the hash matter, so a narrow multiply suffices
    assign w_prod = i_hash_mult[swc_pkg::LOG2_COLS-1:0] * i_sketch_value[swc_pkg::LOG2_COLS-1:0];
    assign w_col  = w_prod + i_hash_offset[swc_pkg::LOG2_COLS-1:0];

    assign w_addr = swc_pkg::ADDR_BITS'({r_row, r_col});

    // weight step with saturation
    assign w_weight = $signed(w_rdata);
    always_comb begin
        if (r_up) begin
            w_weight_new = (w_weight == swc_pkg::WEIGHT_MAX) ? w_weight
                         : w_weight + swc_pkg::WEIGHT_BITS'(1);
        end else begin
            w_weight_new = (w_weight == swc_pkg::WEIGHT_MIN) ? w_weight
                         : w_weight - swc_pkg::WEIGHT_BITS'(1);
        end
    end

    // running sum with saturation
    assign w_acc = swc_pkg::ACC_BITS'(r_sum) + swc_pkg::ACC_BITS'(w_weight);
    always_comb begin
        if (w_acc > swc_pkg::ACC_BITS'(swc_pkg::SUM_MAX)) begin
            w_sum_sat = swc_pkg::SUM_MAX;
        end else if (w_acc < swc_pkg::ACC_BITS'(swc_pkg::SUM_MIN)) begin
            w_sum_sat = swc_pkg::SUM_MIN;
        end else begin
            w_sum_sat = swc_pkg::SUM_BITS'(w_acc);
        end
    end

    // write port: clearing pass or weight update
    assign w_we    = i_cmd.clr || (i_cmd.apply && (r_func == swc_pkg::FUNC_UPDATE));
    assign w_waddr = i_cmd.clr ? r_clr_addr : w_addr;
    assign w_wdata = i_cmd.clr ? '0 : w_weight_new;

    assign w_emit = i_cmd.apply && (r_func == swc_pkg::FUNC_PREDICT) && r_last;

    swc_ram #(
        .WIDTH (swc_pkg::WEIGHT_BITS),
        .DEPTH (swc_pkg::DEPTH)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_last <= i_last;
            r_up   <= i_step_up;
            r_col  <= w_col;
        end
        if (w_emit) begin
            r_out_class <= !w_sum_sat[swc_pkg::SUM_BITS-1] && (w_sum_sat != '0);
            r_out_total <= w_sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_sum       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + swc_pkg::ADDR_BITS'(1);
            end
            if (i_cmd.apply) begin
                if (r_last) begin
                    r_row <= '0;
                    r_sum <= '0;
                end else begin
                    r_row <= (r_row == swc_pkg::ROW_BITS'(swc_pkg::ROWS - 1)) ? '0
                           : r_row + swc_pkg::ROW_BITS'(1);
                    if (r_func == swc_pkg::FUNC_PREDICT) begin
                        r_sum <= w_sum_sat;
                    end
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.last     = r_last;
    assign o_stat.clr_done = (r_clr_addr == swc_pkg::ADDR_BITS'(swc_pkg::DEPTH - 1));
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid        = r_out_valid;
    assign o_predicted_class = r_out_class;
    assign o_weight_total    = r_out_total;

endmodule

### rtl/sketch_weight_classifier_unit.sv
// hashed count-sketch perceptron. the block holds ROWS x 2^LOG2_COLS signed
// saturating weights in one single-port-write ram. each input word carries one
// sketch value and the hash coefficients of the current row; the row comes
// from an internal counter that wraps at ROWS and returns to zero after a word
// with tlast. the column is the low LOG2_COLS bits of mult * value + offset.
// a predict word (tuser = 0) adds the addressed weight into a saturating
// 22-bit sum; a predict word with tlast sends one output word with the class
// (sum >= 1) and the sum. an update word (tuser = 1) steps the addressed weight
// by +1 or -1, saturating, and sends nothing. after reset the ram is cleared
// one entry a cycle, all ROWS * 2^LOG2_COLS (16384 as built), with tready
// low. each word then passes accept, registered ram read and apply/write-back
// before the next word is taken. a closing predict word waits in the apply
// step only while the previous result is still unread.
module sketch_weight_classifier_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // sketch_value [31:0], hash_mult [63:32], hash_offset [95:64],
    // step_up [96], zero [103:97]
    input  logic [swc_pkg::S_DATA_BITS-1:0] i_s_tdata,
    // func [0]: 0 predict, 1 update
    input  logic                            i_s_tuser,
    input  logic                            i_s_tlast,
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // predicted_class [0], weight_total [22:1], zero [23]
    output logic [swc_pkg::M_DATA_BITS-1:0] o_m_tdata
);

    swc_pkg::t_cmd  w_cmd;
    swc_pkg::t_stat w_stat;

    logic                         w_class;
    logic [swc_pkg::SUM_BITS-1:0] w_total;

    // sequencer: clearing pass, accept, read, apply
    swc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // hash, weight ram, row counter, sum and output register
    swc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_func            (i_s_tuser),
        .i_sketch_value    (i_s_tdata[31:0]),
        .i_hash_mult       (i_s_tdata[63:32]),
        .i_hash_offset     (i_s_tdata[95:64]),
        .i_step_up         (i_s_tdata[96]),
        .i_last            (i_s_tlast),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_predicted_class (w_class),
        .o_weight_total    (w_total)
    );

    // pack the result word, padded to whole bytes
    assign o_m_tdata = swc_pkg::M_DATA_BITS'({w_total, w_class});

endmodule

### bench/sketch_weight_classifier_unit_tb.sv
module sketch_weight_classifier_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no word accepted on either side before giving up,
    // covers the ram clearing pass after reset plus the long output hold
    localparam int STALL_LIMIT   = 80000;
    // output hold-off used to back the block up into its input
    localparam int HOLD_CYCLES   = 400;
    // drain time after the last expected result
    localparam int DRAIN_CYCLES  = 20;
    localparam int POOL_SETS     = 4;

    // one input word as the host sees it
    typedef struct {
        logic        func;
        logic [31:0] sval;
        logic [31:0] mult;
        logic [31:0] offs;
        logic        up;
        logic        last;
    } t_sketch_word;

    // one classifier verdict
    typedef struct {
        logic                                cls;
        logic signed [swc_pkg::SUM_BITS-1:0] total;
    } t_sketch_verdict;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    // sketch_value [31:0], hash_mult [63:32], hash_offset [95:64],
    // step_up [96], zero [103:97]
    logic [swc_pkg::S_DATA_BITS-1:0] i_s_tdata = '0;
    // func [0]
    logic                            i_s_tuser = 1'b0;
    logic                            i_s_tlast = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    // predicted_class [0], weight_total [22:1], zero [23]
    logic [swc_pkg::M_DATA_BITS-1:0] o_m_tdata;

    sketch_weight_classifier_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // words waiting to be sent and verdicts waiting to come back
    t_sketch_word    pending_words[$];
    t_sketch_verdict expected_verdicts[$];
    t_sketch_word    next_word;

    // shadow copy of the weight table and the per-vector state
    logic signed [swc_pkg::WEIGHT_BITS-1:0] weight_tab [swc_pkg::DEPTH];
    int row_idx = 0;
    int run_sum = 0;

    int accepted_words = 0;
    int total_words = 0;
    int planned_verdicts = 0;
    int fail_count = 0;
    int stall_cycles = 0;
    int hold_at = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int calm_lo = 0;
    int calm_hi = 0;

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // stretch of the run where neither side idles
    function automatic logic in_calm_stretch();
        return accepted_words >= calm_lo && accepted_words < calm_hi;
    endfunction

    // queue one word, counting the verdicts it will cause
    task automatic push_word(input logic func, input logic [31:0] sval,
                             input logic [31:0] mult, input logic [31:0] offs,
                             input logic up, input logic last);
        t_sketch_word w;
        w.func = func;
        w.sval = sval;
        w.mult = mult;
        w.offs = offs;
        w.up   = up;
        w.last = last;
        pending_words = {pending_words, w};
        if (func == swc_pkg::FUNC_PREDICT && last)
            planned_verdicts++;
    endtask

    // advance the shadow table by one accepted word
    task automatic score_word(input logic func, input logic [31:0] sval,
                              input logic [31:0] mult, input logic [31:0] offs,
                              input logic up, input logic last);
        logic [31:0]     hv;
        int              addr;
        int              acc;
        int              w;
        t_sketch_verdict v;
        hv   = mult * sval + offs;
        addr = row_idx * swc_pkg::COLS + int'(hv[swc_pkg::LOG2_COLS-1:0]);
        if (func == swc_pkg::FUNC_PREDICT) begin
            // saturating partial sum, class decided on the closing word
            acc = run_sum + int'(weight_tab[addr]);
            if (acc > int'(swc_pkg::SUM_MAX))
                acc = int'(swc_pkg::SUM_MAX);
            if (acc < int'(swc_pkg::SUM_MIN))
                acc = int'(swc_pkg::SUM_MIN);
            run_sum = acc;
            if (last) begin
                v.cls   = (acc >= 1);
                v.total = acc[swc_pkg::SUM_BITS-1:0];
                expected_verdicts = {expected_verdicts, v};
            end
        end else begin
            // saturating step of one weight, sum untouched
            w = int'(weight_tab[addr]) + (up ? 1 : -1);
            if (w > int'(swc_pkg::WEIGHT_MAX))
                w = int'(swc_pkg::WEIGHT_MAX);
            if (w < int'(swc_pkg::WEIGHT_MIN))
                w = int'(swc_pkg::WEIGHT_MIN);
            weight_tab[addr] = w[swc_pkg::WEIGHT_BITS-1:0];
        end
        // closing word restarts the vector, otherwise rows wrap at ROWS
        if (last) begin
            row_idx = 0;
            run_sum = 0;
        end else begin
            row_idx = (row_idx + 1) % swc_pkg::ROWS;
        end
    endtask

    // input driver: load a new word when the slot is free, with random gaps outside the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_words.size() != 0 &&
                (in_calm_stretch() || $urandom_range(99) >= 24)) begin
                next_word = pending_words.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {7'b0, next_word.up, next_word.offs,
                               next_word.mult, next_word.sval};
                i_s_tuser  <= next_word.func;
                i_s_tlast  <= next_word.last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // input monitor: every accepted word goes through the shadow table
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            score_word(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32],
                       i_s_tdata[95:64], i_s_tdata[96], i_s_tlast);
            accepted_words <= accepted_words + 1;
        end
    end

    // output receiver: random stalls, one long hold-off to fill the block
    always @(posedge i_clk) begin
        if (!hold_done && hold_at > 0 && accepted_words >= hold_at) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= in_calm_stretch() || $urandom_range(99) >= 24;
        end
    end

    // output monitor: compare each result word with the oldest verdict
    always @(posedge i_clk) begin
        t_sketch_verdict v;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_verdicts.size() == 0) begin
                $error("result word with nothing expected: class %0d total %0d",
                       o_m_tdata[0], $signed(o_m_tdata[22:1]));
                fail_count++;
            end else begin
                v = expected_verdicts.pop_front();
                if (o_m_tdata[0] !== v.cls) begin
                    $error("predicted_class: expected %0d, got %0d", v.cls, o_m_tdata[0]);
                    fail_count++;
                end
                if ($signed(o_m_tdata[22:1]) !== v.total) begin
                    $error("weight_total: expected %0d, got %0d",
                           v.total, $signed(o_m_tdata[22:1]));
                    fail_count++;
                end
            end
        end
    end

    // stall counter for the watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // watchdog
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    // stimulus and end of run
    initial begin
        logic [31:0] pool_sval [POOL_SETS][swc_pkg::ROWS];
        logic [31:0] pool_mult [POOL_SETS][swc_pkg::ROWS];
        logic [31:0] pool_offs [POOL_SETS][swc_pkg::ROWS];
        int          random_start;
        int          n;
        int          k;
        int          s;
        int          len;
        int          mode;
        int          v0;
        logic        dir;
        logic        f;

        foreach (weight_tab[i])
            weight_tab[i] = '0;

        // --- directed words ---
        // all-zero predict, then all-ones fields wrapping the hash to column 0
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        push_word(swc_pkg::FUNC_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  1'b1, 1'b1);
        push_word(swc_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  1'b1, 1'b1);
        // sum of exactly one gives class one
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        // step down twice, predict ignores step_up
        push_word(swc_pkg::FUNC_UPDATE, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        push_word(swc_pkg::FUNC_UPDATE, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
        // mixed modes inside one vector
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        push_word(swc_pkg::FUNC_UPDATE, 32'h0, 32'h0, 32'h11, 1'b1, 1'b0);
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h11, 1'b0, 1'b0);
        push_word(swc_pkg::FUNC_UPDATE, 32'h0, 32'h0, 32'h22, 1'b0, 1'b0);
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h22, 1'b0, 1'b1);
        // vector closed by an update gives nothing
        push_word(swc_pkg::FUNC_UPDATE, 32'h0, 32'h0, 32'h33, 1'b1, 1'b0);
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h33, 1'b0, 1'b0);
        push_word(swc_pkg::FUNC_UPDATE, 32'h0, 32'h0, 32'h33, 1'b1, 1'b1);
        // read back the row-one weight written above
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        push_word(swc_pkg::FUNC_PREDICT, 32'h0, 32'h0, 32'h11, 1'b0, 1'b1);
        // high multiplier bit and top column
        push_word(swc_pkg::FUNC_UPDATE, 32'h3, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_word(swc_pkg::FUNC_PREDICT, 32'h3, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1);
        push_word(swc_pkg::FUNC_PREDICT, 32'hFFFF_FFFF, 32'h0, 32'h8000_00FF, 1'b0, 1'b1);

        // --- random vectors ---
        // a few fixed sketches so updates and predicts meet on the same weights
        foreach (pool_sval[i, j]) begin
            pool_sval[i][j] = $urandom;
            pool_mult[i][j] = $urandom;
            pool_offs[i][j] = $urandom;
        end
        random_start = pending_words.size();
        v0 = planned_verdicts;
        n = 0;
        while (n < 1100 || planned_verdicts - v0 < 40) begin
            // mostly short vectors, now and then one that wraps the rows
            if ($urandom_range(9) == 0)
                len = $urandom_range(swc_pkg::ROWS + 1, swc_pkg::ROWS + 36);
            else
                len = $urandom_range(1, 16);
            mode = $urandom_range(99);
            s    = $urandom_range(POOL_SETS - 1);
            dir  = 1'($urandom_range(1));
            for (k = 0; k < len; k++) begin
                if (mode < 35)
                    f = swc_pkg::FUNC_UPDATE;
                else if (mode < 70)
                    f = swc_pkg::FUNC_PREDICT;
                else
                    f = 1'($urandom_range(1));
                if (mode < 85) begin
                    // well-formed vector on a pooled sketch, mostly one direction
                    push_word(f, pool_sval[s][k % swc_pkg::ROWS],
                              pool_mult[s][k % swc_pkg::ROWS],
                              pool_offs[s][k % swc_pkg::ROWS],
                              ($urandom_range(9) < 8) ? dir : !dir, k == len - 1);
                end else begin
                    // noise with stray closing words in the middle
                    push_word(f, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                              k == len - 1 || $urandom_range(19) == 0);
                end
            end
            n += len;
        end
        total_words = pending_words.size();
        hold_at = random_start + 100;
        calm_lo = random_start + 400;
        calm_hi = random_start + 800;

        // synchronous reset, then the block clears its ram on its own
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_words != total_words)
            @(posedge i_clk);
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sketch_weight_classifier_unit.f
rtl/swc_pkg.sv
rtl/swc_ram.sv
rtl/swc_ctrl.sv
rtl/swc_datapath.sv
rtl/sketch_weight_classifier_unit.sv
bench/sketch_weight_classifier_unit_tb.sv
